// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rds check failed");

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rds check failed");

`endif

// ----- design/rds_pkg.sv -----
// Shared constants, payload types and controller/datapath interface types.
package rds_pkg;

    localparam int MAX_ROW_WIDTH = 1024;
    localparam int AW = $clog2(MAX_ROW_WIDTH);
    localparam int CW = AW + 1;
    localparam int PW = CW + 2;

    localparam int DEPTH_W = 9;
    localparam int BYTE_W  = 8;
    localparam int MU_W    = 8;
    localparam int EYE_W   = 10;
    localparam int RW_W    = 11;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 11;

    localparam int MD_W    = 17;
    localparam int STEP_W  = 18;
    localparam int NUM_W   = 27;
    localparam int N_W     = 28;
    localparam int REM_W   = 20;
    localparam int SEP_W   = 10;
    localparam int K_W     = 18;
    localparam int Z_W     = 27;
    localparam int DIVC_W  = 5;

    localparam logic [DEPTH_W-1:0] DEPTH_ONE  = 9'd256;
    localparam logic [MD_W-1:0]    HALF_SCALE = 17'd65536;
    localparam logic [STEP_W-1:0]  FULL_SCALE = 18'd131072;
    localparam logic [BYTE_W-1:0]  WHITE      = 8'd255;
    localparam logic [BYTE_W-1:0]  BLACK      = 8'd0;

    localparam logic [IDX_W-1:0] REG_DEPTH_FACTOR = 3'd0;
    localparam logic [IDX_W-1:0] REG_EYE_PIXELS   = 3'd1;
    localparam logic [IDX_W-1:0] REG_HIDE         = 3'd2;
    localparam logic [IDX_W-1:0] REG_TWO_COLOUR   = 3'd3;
    localparam logic [IDX_W-1:0] REG_ROW_WIDTH    = 3'd4;
    localparam logic [IDX_W-1:0] REG_BORDER_DEPTH = 3'd5;

    localparam logic [MU_W-1:0]    RST_DEPTH_FACTOR = 8'd85;
    localparam logic [EYE_W-1:0]   RST_EYE_PIXELS   = 10'd180;
    localparam logic [RW_W-1:0]    RST_ROW_WIDTH    = 11'd1024;
    localparam logic [DEPTH_W-1:0] RST_BORDER_DEPTH = 9'd0;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EMIT = 1'b1;

    typedef struct packed {
        logic               op;
        logic [DEPTH_W-1:0] depth;
        logic [BYTE_W-1:0]  random_byte;
        logic               row_end;
    } rds_in_t;

    typedef struct packed {
        logic [AW-1:0]     pixel_index;
        logic [BYTE_W-1:0] colour;
        logic              row_last;
    } rds_out_t;

    typedef struct packed {
        logic load_wr;
        logic emit_take;
        logic out_load;
        logic init_start;
        logic init_wr;
        logic px_start;
        logic px_md;
        logic px_num;
        logic div_start;
        logic div_step;
        logic pair_calc;
        logic hs_start;
        logic hs_rd;
        logic hs_mul;
        logic hs_cmp;
        logic ch_rd;
        logic ch_ev;
        logic px_next;
        logic col_start;
        logic col_p;
        logic col_cp;
        logic col_dec;
        logic finish;
    } rds_cmd_t;

    typedef struct packed {
        logic x_last;
        logic x_zero;
        logic emit_pending;
        logic out_free;
        logic div_last;
        logic pair_ok;
        logic hs_needed;
        logic hs_vis;
        logic hs_more;
        logic chain_more;
        logic col_same;
    } rds_status_t;

    function automatic logic [DEPTH_W-1:0] sat_depth(input logic [DEPTH_W-1:0] d);
        return (d > DEPTH_ONE) ? DEPTH_ONE : d;
    endfunction

endpackage

// ----- design/rds_ctrl.sv -----
// Sequencer for loading, row linking, colour fixing and emission.
module rds_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_accept,
    input  logic                 in_op,
    input  logic                 in_row_end,
    output logic                 s_ready,
    input  rds_pkg::rds_status_t status,
    output rds_pkg::rds_cmd_t    cmd
);
    import rds_pkg::*;

    typedef enum logic [18:0] {
        ST_IDLE     = 19'h00001,
        ST_E_OUT    = 19'h00002,
        ST_INIT     = 19'h00004,
        ST_PX_RD    = 19'h00008,
        ST_PX_MD    = 19'h00010,
        ST_PX_NUM   = 19'h00020,
        ST_DIV_LD   = 19'h00040,
        ST_DIV      = 19'h00080,
        ST_PAIR     = 19'h00100,
        ST_HS_START = 19'h00200,
        ST_HS_RD    = 19'h00400,
        ST_HS_MUL   = 19'h00800,
        ST_HS_CMP   = 19'h01000,
        ST_CH_RD    = 19'h02000,
        ST_CH_EV    = 19'h04000,
        ST_PX_NEXT  = 19'h08000,
        ST_COL_RD   = 19'h10000,
        ST_COL_P    = 19'h20000,
        ST_COL_CP   = 19'h40000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (in_op == OP_LOAD) begin
                        cmd.load_wr = 1'b1;
                        if (in_row_end) begin
                            cmd.init_start = 1'b1;
                            state_next     = ST_INIT;
                        end
                    end else if (status.emit_pending) begin
                        cmd.emit_take = 1'b1;
                        state_next    = ST_E_OUT;
                    end
                end
            end
            ST_E_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_INIT: begin
                cmd.init_wr = 1'b1;
                if (status.x_last) begin
                    cmd.px_start = 1'b1;
                    state_next   = ST_PX_RD;
                end
            end
            ST_PX_RD: begin
                state_next = ST_PX_MD;
            end
            ST_PX_MD: begin
                cmd.px_md  = 1'b1;
                state_next = ST_PX_NUM;
            end
            ST_PX_NUM: begin
                cmd.px_num = 1'b1;
                state_next = ST_DIV_LD;
            end
            ST_DIV_LD: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_PAIR;
                end
            end
            ST_PAIR: begin
                cmd.pair_calc = 1'b1;
                if (!status.pair_ok) begin
                    state_next = ST_PX_NEXT;
                end else if (status.hs_needed) begin
                    state_next = ST_HS_START;
                end else begin
                    state_next = ST_CH_RD;
                end
            end
            ST_HS_START: begin
                cmd.hs_start = 1'b1;
                state_next   = ST_HS_RD;
            end
            ST_HS_RD: begin
                cmd.hs_rd  = 1'b1;
                state_next = ST_HS_MUL;
            end
            ST_HS_MUL: begin
                cmd.hs_mul = 1'b1;
                state_next = ST_HS_CMP;
            end
            ST_HS_CMP: begin
                cmd.hs_cmp = 1'b1;
                if (!status.hs_vis) begin
                    state_next = ST_PX_NEXT;
                end else if (status.hs_more) begin
                    state_next = ST_HS_RD;
                end else begin
                    state_next = ST_CH_RD;
                end
            end
            ST_CH_RD: begin
                cmd.ch_rd  = 1'b1;
                state_next = ST_CH_EV;
            end
            ST_CH_EV: begin
                cmd.ch_ev = 1'b1;
                if (status.chain_more) begin
                    state_next = ST_CH_RD;
                end else begin
                    state_next = ST_PX_NEXT;
                end
            end
            ST_PX_NEXT: begin
                cmd.px_next = 1'b1;
                if (status.x_last) begin
                    cmd.col_start = 1'b1;
                    state_next    = ST_COL_RD;
                end else begin
                    state_next = ST_PX_RD;
                end
            end
            ST_COL_RD: begin
                state_next = ST_COL_P;
            end
            ST_COL_P: begin
                cmd.col_p = 1'b1;
                if (!status.col_same) begin
                    state_next = ST_COL_CP;
                end else if (status.x_zero) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    cmd.col_dec = 1'b1;
                    state_next  = ST_COL_RD;
                end
            end
            ST_COL_CP: begin
                cmd.col_cp = 1'b1;
                if (status.x_zero) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    cmd.col_dec = 1'b1;
                    state_next  = ST_COL_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/rds_dp.sv -----
// Datapath: settings, row memories, separation divider, surface test and chain walk.
module rds_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [rds_pkg::IDX_W-1:0]   cfg_index,
    input  logic [rds_pkg::CFG_W-1:0]   cfg_data,
    input  rds_pkg::rds_in_t            s_payload,
    input  rds_pkg::rds_cmd_t           cmd,
    output rds_pkg::rds_status_t        status,
    output logic                        m_valid,
    input  logic                        m_ready,
    output rds_pkg::rds_out_t           m_payload
);
    import rds_pkg::*;

    logic [MU_W-1:0]    depth_factor_reg;
    logic [EYE_W-1:0]   eye_pixels_reg;
    logic               hide_reg;
    logic               mono_reg;
    logic [RW_W-1:0]    row_width_reg;
    logic [DEPTH_W-1:0] border_reg;

    logic [CW-1:0] w_act;
    logic [CW-1:0] load_cnt_reg, emit_cnt_reg, emit_dec;
    logic          load_store;

    logic [DEPTH_W-1:0] depth_mem  [MAX_ROW_WIDTH];
    logic [BYTE_W-1:0]  rand_mem   [MAX_ROW_WIDTH];
    logic [AW-1:0]      link_mem   [MAX_ROW_WIDTH];
    logic [BYTE_W-1:0]  colour_mem [MAX_ROW_WIDTH];

    logic [DEPTH_W-1:0] depth_rd_a_reg, depth_rd_b_reg;
    logic [BYTE_W-1:0]  rand_rd_reg, colour_rd_reg;
    logic [AW-1:0]      link_rd_reg;
    logic [AW-1:0]      depth_raddr_a, link_raddr, colour_raddr;

    logic [AW-1:0]      x_reg;
    logic [CW-1:0]      t_reg;
    logic [K_W-1:0]     k_reg;
    logic [MD_W-1:0]    md_reg;
    logic [DEPTH_W-1:0] d_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [STEP_W-1:0]  den_reg;

    logic [N_W-1:0]     n_reg;
    logic [REM_W-1:0]   rem_reg, rem_sh, div_d;
    logic               rem_ge;
    logic [SEP_W-1:0]   q_reg;
    logic [DIVC_W-1:0]  div_cnt_reg;

    logic signed [PW-1:0] lo_s, hi_s, xa_s, xb_s;
    logic [AW-1:0]      lo_reg, hi_reg;
    logic               oob_a_reg, oob_b_reg;
    logic [DEPTH_W-1:0] d_sat, dn_a, dn_b, border_sat;
    logic [Z_W-1:0]     z_reg, pa_reg, pb_reg, k_lim, z_step;

    logic [BYTE_W-1:0]  free_colour;
    logic               chain_more, col_same;

    rds_out_t m_payload_reg;
    logic     m_valid_reg;

    // Settings.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_factor_reg <= RST_DEPTH_FACTOR;
            eye_pixels_reg   <= RST_EYE_PIXELS;
            hide_reg         <= 1'b1;
            mono_reg         <= 1'b0;
            row_width_reg    <= RST_ROW_WIDTH;
            border_reg       <= RST_BORDER_DEPTH;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DEPTH_FACTOR: depth_factor_reg <= cfg_data[MU_W-1:0];
                REG_EYE_PIXELS:   eye_pixels_reg   <= cfg_data[EYE_W-1:0];
                REG_HIDE:         hide_reg         <= cfg_data[0];
                REG_TWO_COLOUR:   mono_reg         <= cfg_data[0];
                REG_ROW_WIDTH:    row_width_reg    <= cfg_data[RW_W-1:0];
                REG_BORDER_DEPTH: border_reg       <= cfg_data[DEPTH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (row_width_reg == '0) begin
            w_act = CW'(1);
        end else if (32'(row_width_reg) > 32'(MAX_ROW_WIDTH)) begin
            w_act = CW'(MAX_ROW_WIDTH);
        end else begin
            w_act = CW'(row_width_reg);
        end
    end

    always_ff @(posedge aclk) begin
        k_reg <= K_W'(depth_factor_reg) * K_W'(eye_pixels_reg);
    end

    // Counters.
    assign load_store = cmd.load_wr && (load_cnt_reg < w_act);
    assign emit_dec   = emit_cnt_reg - CW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_cnt_reg <= '0;
            emit_cnt_reg <= '0;
        end else begin
            if (cmd.finish) begin
                load_cnt_reg <= '0;
            end else if (load_store) begin
                load_cnt_reg <= load_cnt_reg + CW'(1);
            end
            if (cmd.finish) begin
                emit_cnt_reg <= w_act;
            end else if (cmd.emit_take) begin
                emit_cnt_reg <= emit_dec;
            end
        end
    end

    // Column pointer.
    always_ff @(posedge aclk) begin
        if (cmd.col_start) begin
            x_reg <= AW'(w_act - CW'(1));
        end else if (cmd.px_start || cmd.init_start) begin
            x_reg <= '0;
        end else if (cmd.init_wr || cmd.px_next) begin
            x_reg <= x_reg + AW'(1);
        end else if (cmd.col_dec) begin
            x_reg <= x_reg - AW'(1);
        end
    end

    // Depth and random memories.
    assign xa_s = $signed(PW'(x_reg)) - $signed(PW'(t_reg));
    assign xb_s = $signed(PW'(x_reg)) + $signed(PW'(t_reg));
    assign depth_raddr_a = cmd.hs_rd ? xa_s[AW-1:0] : x_reg;

    always_ff @(posedge aclk) begin
        if (load_store) begin
            depth_mem[load_cnt_reg[AW-1:0]] <= s_payload.depth;
            rand_mem[load_cnt_reg[AW-1:0]]  <= s_payload.random_byte;
        end
        depth_rd_a_reg <= depth_mem[depth_raddr_a];
        depth_rd_b_reg <= depth_mem[xb_s[AW-1:0]];
        rand_rd_reg    <= rand_mem[x_reg];
        oob_a_reg      <= xa_s[PW-1];
        oob_b_reg      <= (xb_s >= $signed(PW'(w_act)));
    end

    // Separation: products, then a restoring divider, one quotient bit a cycle.
    assign d_sat  = sat_depth(depth_rd_a_reg);
    assign div_d  = REM_W'({den_reg, 1'b0});
    assign rem_sh = {rem_reg[REM_W-2:0], n_reg[N_W-1]};
    assign rem_ge = (rem_sh >= div_d);

    always_ff @(posedge aclk) begin
        if (cmd.px_md) begin
            md_reg <= MD_W'(depth_factor_reg) * MD_W'(d_sat);
            d_reg  <= d_sat;
        end
        if (cmd.px_num) begin
            num_reg <= NUM_W'(HALF_SCALE - md_reg) * NUM_W'(eye_pixels_reg);
            den_reg <= FULL_SCALE - STEP_W'(md_reg);
        end
        if (cmd.div_start) begin
            n_reg       <= {num_reg, 1'b0} + N_W'(den_reg);
            rem_reg     <= '0;
            q_reg       <= '0;
            div_cnt_reg <= DIVC_W'(N_W - 1);
        end else if (cmd.div_step) begin
            n_reg       <= {n_reg[N_W-2:0], 1'b0};
            rem_reg     <= rem_ge ? (rem_sh - div_d) : rem_sh;
            q_reg       <= {q_reg[SEP_W-2:0], rem_ge};
            div_cnt_reg <= div_cnt_reg - DIVC_W'(1);
        end
    end

    // Eye pair around the column.
    assign lo_s = $signed(PW'(x_reg)) - $signed(PW'(q_reg >> 1));
    assign hi_s = lo_s + $signed(PW'(q_reg));

    always_ff @(posedge aclk) begin
        if (cmd.pair_calc) begin
            lo_reg <= lo_s[AW-1:0];
            hi_reg <= hi_s[AW-1:0];
        end else if (cmd.ch_ev && chain_more) begin
            lo_reg <= link_rd_reg;
        end
    end

    // Hidden-surface test; each step reads, multiplies, then compares.
    assign border_sat = sat_depth(border_reg);
    assign dn_a   = oob_a_reg ? border_sat : sat_depth(depth_rd_a_reg);
    assign dn_b   = oob_b_reg ? border_sat : sat_depth(depth_rd_b_reg);
    assign k_lim  = Z_W'({k_reg, 8'b0});
    assign z_step = Z_W'({den_reg, 1'b0});

    always_ff @(posedge aclk) begin
        if (cmd.hs_start) begin
            z_reg <= Z_W'(d_reg) * Z_W'(k_reg) + z_step;
            t_reg <= CW'(1);
        end else if (cmd.hs_cmp) begin
            z_reg <= z_reg + z_step;
            t_reg <= t_reg + CW'(1);
        end
        if (cmd.hs_mul) begin
            pa_reg <= Z_W'(dn_a) * Z_W'(k_reg);
            pb_reg <= Z_W'(dn_b) * Z_W'(k_reg);
        end
    end

    // Link memory: identity sweep, chain walk, colour pass.
    assign chain_more = (link_rd_reg != lo_reg) && (link_rd_reg != hi_reg)
                        && (link_rd_reg < hi_reg);
    assign link_raddr = cmd.ch_rd ? lo_reg : x_reg;

    always_ff @(posedge aclk) begin
        if (cmd.init_wr) begin
            link_mem[x_reg] <= x_reg;
        end else if (cmd.ch_ev && !chain_more) begin
            link_mem[lo_reg] <= hi_reg;
        end
        link_rd_reg <= link_mem[link_raddr];
    end

    // Colour memory.
    assign col_same     = (link_rd_reg == x_reg);
    assign free_colour  = mono_reg ? (rand_rd_reg[0] ? WHITE : BLACK) : rand_rd_reg;
    assign colour_raddr = cmd.col_p ? link_rd_reg : emit_dec[AW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.col_p && col_same) begin
            colour_mem[x_reg] <= free_colour;
        end else if (cmd.col_cp) begin
            colour_mem[x_reg] <= colour_rd_reg;
        end
        if (cmd.col_p || cmd.emit_take) begin
            colour_rd_reg <= colour_mem[colour_raddr];
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_payload_reg.pixel_index <= emit_cnt_reg[AW-1:0];
            m_payload_reg.colour      <= colour_rd_reg;
            m_payload_reg.row_last    <= (emit_cnt_reg == '0);
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    assign status.x_last       = (CW'(x_reg) == (w_act - CW'(1)));
    assign status.x_zero       = (x_reg == '0);
    assign status.emit_pending = (emit_cnt_reg != '0);
    assign status.out_free     = !m_valid_reg || m_ready;
    assign status.div_last     = (div_cnt_reg == '0);
    assign status.pair_ok      = !lo_s[PW-1] && (hi_s < $signed(PW'(w_act)));
    assign status.hs_needed    = hide_reg && (k_reg != '0);
    assign status.hs_vis       = (pa_reg < z_reg) && (pb_reg < z_reg);
    assign status.hs_more      = (z_reg < k_lim);
    assign status.chain_more   = chain_more;
    assign status.col_same     = col_same;

endmodule

// ----- design/random_dot_stereogram_row.sv -----
// Top level of the random-dot stereogram row generator.
// The input channel (s_valid, s_ready, s_payload) carries two kinds of beat. A load
// beat stores one depth sample and one random byte for the next column, left to
// right; s_ready stays high after a plain load. A load beat with row_end set also
// starts linking the row: every column pair is built, optionally checked for hidden
// surfaces, merged into the row's same-colour chains, and then all colours are fixed
// from right to left. Linking first sweeps the link memory, then per column forms the
// products, runs the divider and takes any hidden-surface steps and chain hops, then
// runs the colour pass; s_ready is low meanwhile. An emit beat returns the colour of
// the next column from right to left on the result channel (m_valid, m_ready,
// m_payload); the result is registered once the output register is free, and an emit
// with nothing pending gives no result. The result sits in an output register; the
// block takes the next beat while it waits, but a further emit holds s_ready low until
// the waiting result is taken. Settings are written through cfg_we, cfg_index and
// cfg_data; the user must write them only while the block is idle, which the block
// does not enforce. Reset restores the default settings and empties both counters;
// the row memories keep no reset value and the link memory is rebuilt at every row end.
module random_dot_stereogram_row (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [rds_pkg::IDX_W-1:0] cfg_index,
    input  logic [rds_pkg::CFG_W-1:0] cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  rds_pkg::rds_in_t          s_payload,
    output logic                      m_valid,
    input  logic                      m_ready,
    output rds_pkg::rds_out_t         m_payload
);
    import rds_pkg::*;

    rds_cmd_t    cmd;
    rds_status_t status;
    logic        in_accept;

    // A beat is taken only while the sequencer waits in its idle state.
    assign in_accept = s_valid && s_ready;

    rds_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .in_op      (s_payload.op),
        .in_row_end (s_payload.row_end),
        .s_ready    (s_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // The datapath owns settings, memories, arithmetic and the output register.
    rds_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_payload (s_payload),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

// ----- design/rds_checker.sv -----
// Port-level checks for the stereogram row block, bound to its top level.
`include "assert_macros.svh"

module rds_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input rds_pkg::rds_in_t          s_payload,
    input logic                      m_valid,
    input logic                      m_ready,
    input rds_pkg::rds_out_t         m_payload
);
    import rds_pkg::*;

    // A stalled result stays offered and unchanged.
    `ASSERT_NEXT(a_m_hold, m_valid && !m_ready, m_valid)
    `ASSERT_NEXT(a_m_stable, m_valid && !m_ready, $stable(m_payload))

    // A plain load never blocks the next beat.
    `ASSERT_NEXT(a_load_ready, s_valid && s_ready && s_payload.op == OP_LOAD && !s_payload.row_end, s_ready)

    // A row end starts linking, so the input closes at once.
    `ASSERT_NEXT(a_row_busy, s_valid && s_ready && s_payload.op == OP_LOAD && s_payload.row_end, !s_ready)

    // A new result is loaded only from the emit state, never straight from idle.
    `ASSERT_IMPL(a_out_after_emit, $rose(m_valid), !$past(s_ready))

endmodule

bind random_dot_stereogram_row rds_checker u_rds_checker (.*);
